// ----- sv/qbz_pkg.sv -----
// Shared types and constants for the quadratic Bezier point sampler.
// No dependencies; imported by every module of the block.
`default_nettype none

package qbz_pkg;

    // Configuration register and fixed-point formats
    localparam int STEP_BITS = 7;            // step_count register width
    localparam logic [STEP_BITS-1:0] STEP_RESET = 7'd11;
    localparam int T_BITS    = 16;           // t is unsigned Q0.16
    localparam int Q_BITS    = T_BITS + 1;   // holds 1.0 in Q0.16
    localparam int W_BITS    = 2 * T_BITS;   // Q0.32 blend weights
    localparam int CNT_BITS  = 5;            // reciprocal step counter, Q_BITS steps

    // Controller -> datapath
    typedef struct packed {
        logic div_start;  // recompute the per-point t increment
        logic load;       // capture a new curve, rewind point counter
        logic issue;      // launch the current point into the pipeline
    } qbz_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic advance;    // pipeline moves this cycle
        logic div_busy;   // increment unit still working
        logic at_last;    // current point is the end anchor
    } qbz_stat_t;

endpackage

`default_nettype wire

// ----- sv/quad_bezier_point_sampler.sv -----
// Top level of the quadratic Bezier point sampler.
// Depends on qbz_pkg, qbz_ctrl, qbz_datapath (which holds qbz_recip).
//
// Usage:
//  - Input channel (in_valid / in_stall): one beat is one curve, start,
//    control and end points in signed Q12.4.
//  - Output channel (out_valid / out_stall): one beat per sampled point;
//    a curve yields n points, n = step_count held to [2, MAX_STEPS].
//    last_point marks the end anchor, which is the curve's final beat.
//  - cfg_write / cfg_data load step_count; write only while idle.
//  - Throughput: one point per cycle unless out_stall holds a beat.
//    A new curve is taken in the cycle the previous curve's end
//    anchor is issued.
//  - After acceptance the first point is issued and passes the weight
//    stage, product stage and sum/round output register to out_valid.
//  - Reset and every config write start a setup in which a serial
//    divider finds the t increment 2^16/(n-1); in_stall is high
//    throughout.
//  - When out_stall holds a beat, the whole point pipeline freezes and
//    issue of further points pauses; nothing is dropped.
`default_nettype none

module quad_bezier_point_sampler #(
    parameter int MAX_STEPS  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [qbz_pkg::STEP_BITS-1:0]  cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [COORD_BITS-1:0]   start_x,
    input  wire logic signed [COORD_BITS-1:0]   start_y,
    input  wire logic signed [COORD_BITS-1:0]   ctrl_x,
    input  wire logic signed [COORD_BITS-1:0]   ctrl_y,
    input  wire logic signed [COORD_BITS-1:0]   end_x,
    input  wire logic signed [COORD_BITS-1:0]   end_y,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [COORD_BITS-1:0]        point_x,
    output logic signed [COORD_BITS-1:0]        point_y,
    output logic                                last_point
);
    import qbz_pkg::*;

    qbz_cmd_t              cmd;
    qbz_stat_t             stat;
    logic [COORD_BITS-1:0] coord_in [0:5];
    logic [COORD_BITS-1:0] px, py;

    // curve store order matches the input beat fields
    assign coord_in[0] = start_x;
    assign coord_in[1] = start_y;
    assign coord_in[2] = ctrl_x;
    assign coord_in[3] = ctrl_y;
    assign coord_in[4] = end_x;
    assign coord_in[5] = end_y;

    qbz_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    qbz_datapath #(
        .MAX_STEPS  (MAX_STEPS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .coord_in   (coord_in),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .point_x    (px),
        .point_y    (py),
        .last_point (last_point)
    );

    assign point_x = px;
    assign point_y = py;

endmodule

`default_nettype wire

// ----- sv/qbz_recip.sv -----
// Bit-serial restoring divider: 2^16 / span, giving t step quotient and
// doubled remainder. One quotient bit per cycle. Uses qbz_pkg.
`default_nettype none

module qbz_recip #(
    parameter int SPAN_W = 6
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [SPAN_W-1:0]         divisor,
    output logic                           busy,
    output logic [qbz_pkg::Q_BITS-1:0]     quot,
    output logic [SPAN_W:0]                rem2
);
    import qbz_pkg::*;

    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SPAN_W-1:0]   dvs_reg, dvs_next;
    logic [SPAN_W-1:0]   rem_reg, rem_next;
    logic [Q_BITS-1:0]   quot_reg, quot_next;

    logic                in_bit;
    logic [SPAN_W:0]     rem_sh;
    logic [SPAN_W:0]     rem_sub;
    logic                ge;

    // dividend is 1 << T_BITS: only its top bit is set
    assign in_bit  = (cnt_reg == CNT_BITS'(T_BITS));
    assign rem_sh  = {rem_reg, in_bit};
    assign ge      = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(Q_BITS - 1);
            dvs_next  = divisor;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sub[SPAN_W-1:0] : rem_sh[SPAN_W-1:0];
            quot_next = {quot_reg[Q_BITS-2:0], ge};
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign rem2 = {rem_reg, 1'b0};

endmodule

`default_nettype wire

// ----- sv/qbz_datapath.sv -----
// Datapath: step_count register, curve store, t accumulator, and the
// three-stage weight / product / sum pipeline. Uses qbz_pkg, qbz_recip.
`default_nettype none

module qbz_datapath #(
    parameter int MAX_STEPS  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire qbz_pkg::qbz_cmd_t              cmd,
    output qbz_pkg::qbz_stat_t                  stat,
    input  wire logic                           cfg_write,
    input  wire logic [qbz_pkg::STEP_BITS-1:0]  cfg_data,
    input  wire logic [COORD_BITS-1:0]          coord_in [0:5],
    input  wire logic                           out_stall,
    output logic                                out_valid,
    output logic [COORD_BITS-1:0]               point_x,
    output logic [COORD_BITS-1:0]               point_y,
    output logic                                last_point
);
    import qbz_pkg::*;

    localparam int SPAN_W = (MAX_STEPS > 2) ? $clog2(MAX_STEPS) : 1;
    localparam int PROD_W = W_BITS + COORD_BITS;
    localparam logic [COORD_BITS-1:0] SIGN_FLIP = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [PROD_W-1:0]     ROUND_HALF = PROD_W'(1) << (W_BITS - 1);

    // configuration and step constants
    logic [STEP_BITS-1:0] step_count_reg;
    logic [STEP_BITS-1:0] n_eff;
    logic [SPAN_W-1:0]    span;
    logic [Q_BITS-1:0]    step_quot;
    logic [SPAN_W:0]      step_rem2;
    logic                 div_busy;

    // curve store and point sequencing
    logic [COORD_BITS-1:0] cur_reg [0:5];
    logic [SPAN_W-1:0]     idx_reg;
    logic [Q_BITS-1:0]     acc_q_reg, acc_q_next;
    logic [SPAN_W:0]       acc_r_reg, acc_r_next;
    logic [SPAN_W+1:0]     r_sum, r_div;
    logic                  r_wrap;

    // pipeline
    logic                  advance;
    logic [T_BITS-1:0]     t16, u16;
    logic [W_BITS-1:0]     uu, tu, tt;

    logic                  s1_valid_reg, s1_last_reg, s1_pass_reg;
    logic [COORD_BITS-1:0] s1_px_reg, s1_py_reg;
    logic [W_BITS-1:0]     s1_w_reg [0:2];
    logic [COORD_BITS-1:0] s1_c_reg [0:5];

    logic                  s2_valid_reg, s2_last_reg, s2_pass_reg;
    logic [COORD_BITS-1:0] s2_px_reg, s2_py_reg;
    logic [PROD_W-1:0]     s2_p_reg [0:5];
    logic [PROD_W-1:0]     prod [0:5];

    logic [PROD_W-1:0]     sum_x, sum_y;
    logic                  out_valid_reg, out_last_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;

    // ---------------- step count and increment unit ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_count_reg <= STEP_RESET;
        else if (cfg_write)
            step_count_reg <= cfg_data;
    end

    always_comb
    begin
        if (step_count_reg < STEP_BITS'(2))
            n_eff = STEP_BITS'(2);
        else if (step_count_reg > STEP_BITS'(MAX_STEPS))
            n_eff = STEP_BITS'(MAX_STEPS);
        else
            n_eff = step_count_reg;
    end
    assign span = SPAN_W'(n_eff - 1'b1);

    qbz_recip #(.SPAN_W(SPAN_W)) u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .divisor (span),
        .busy    (div_busy),
        .quot    (step_quot),
        .rem2    (step_rem2)
    );

    // ---------------- curve store, index, t accumulator ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < 6; k++)
                cur_reg[k] <= coord_in[k];
        end
    end

    // t_i = floor((2*i*2^16 + span) / (2*span)) tracked as quotient + remainder
    assign r_sum  = {1'b0, acc_r_reg} + {1'b0, step_rem2};
    assign r_div  = {1'b0, span, 1'b0};
    assign r_wrap = (r_sum >= r_div);

    always_comb
    begin
        acc_q_next = acc_q_reg;
        acc_r_next = acc_r_reg;
        if (cmd.load)
        begin
            acc_q_next = '0;
            acc_r_next = {1'b0, span};
        end
        else if (cmd.issue)
        begin
            acc_r_next = r_wrap ? (SPAN_W+1)'(r_sum - r_div) : r_sum[SPAN_W:0];
            acc_q_next = acc_q_reg + step_quot + Q_BITS'(r_wrap);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            acc_q_reg <= '0;
            acc_r_reg <= '0;
        end
        else
        begin
            acc_q_reg <= acc_q_next;
            acc_r_reg <= acc_r_next;
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.issue)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    // ---------------- stage 1: weights ----------------
    assign advance = !out_valid_reg || !out_stall;
    assign t16 = acc_q_reg[T_BITS-1:0];
    assign u16 = T_BITS'(0) - t16;
    assign uu  = u16 * u16;
    assign tu  = t16 * u16;
    assign tt  = t16 * t16;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_last_reg <= stat.at_last;
            s1_pass_reg <= (idx_reg == '0) || stat.at_last;
            s1_px_reg   <= stat.at_last ? cur_reg[4] : cur_reg[0];
            s1_py_reg   <= stat.at_last ? cur_reg[5] : cur_reg[1];
            s1_w_reg[0] <= uu;
            s1_w_reg[1] <= {tu[W_BITS-2:0], 1'b0};
            s1_w_reg[2] <= tt;
            for (int k = 0; k < 6; k++)
                s1_c_reg[k] <= cur_reg[k] ^ SIGN_FLIP;  // offset binary
        end
    end

    // ---------------- stage 2: weight x coordinate ----------------
    always_comb
    begin
        for (int k = 0; k < 6; k++)
            prod[k] = PROD_W'(s1_w_reg[k >> 1]) * PROD_W'(s1_c_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_last_reg <= s1_last_reg;
            s2_pass_reg <= s1_pass_reg;
            s2_px_reg   <= s1_px_reg;
            s2_py_reg   <= s1_py_reg;
            for (int k = 0; k < 6; k++)
                s2_p_reg[k] <= prod[k];
        end
    end

    // ---------------- stage 3: sum, round, output register ----------------
    // weights sum to 2^32 for interior t, so the rounded sum always fits COORD_BITS
    assign sum_x = s2_p_reg[0] + s2_p_reg[2] + s2_p_reg[4] + ROUND_HALF;
    assign sum_y = s2_p_reg[1] + s2_p_reg[3] + s2_p_reg[5] + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_last_reg <= s2_last_reg;
            out_x_reg    <= s2_pass_reg ? s2_px_reg
                                        : (sum_x[PROD_W-1:W_BITS] ^ SIGN_FLIP);
            out_y_reg    <= s2_pass_reg ? s2_py_reg
                                        : (sum_y[PROD_W-1:W_BITS] ^ SIGN_FLIP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign stat.advance  = advance;
    assign stat.div_busy = div_busy;
    assign stat.at_last  = (idx_reg == span);

    assign out_valid  = out_valid_reg;
    assign point_x    = out_x_reg;
    assign point_y    = out_y_reg;
    assign last_point = out_last_reg;

    // interior points must have 0 < t < 1
    a_interior_t: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && idx_reg != '0 && !stat.at_last)
        |-> (acc_q_reg[T_BITS] == 1'b0 && acc_q_reg[T_BITS-1:0] != '0))
        else $error("interior t out of range");

    a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && stat.at_last) |=> (s1_valid_reg && s1_last_reg))
        else $error("end anchor lost its last tag");

endmodule

`default_nettype wire

// ----- sv/qbz_ctrl.sv -----
// Controller FSM: increment setup after reset or config write, curve
// acceptance, and point issue. Uses qbz_pkg.
`default_nettype none

module qbz_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output qbz_pkg::qbz_cmd_t        cmd,
    input  wire qbz_pkg::qbz_stat_t  stat
);
    import qbz_pkg::*;

    typedef enum logic [3:0] {
        ST_START = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_IDLE  = 4'b0100,
        ST_RUN   = 4'b1000
    } qbz_state_t;

    qbz_state_t state_reg, state_next;
    logic       issue;
    logic       accept;
    logic       can_take;

    assign issue    = (state_reg == ST_RUN) && stat.advance;
    // next curve may enter as the current end anchor is issued
    assign can_take = (state_reg == ST_IDLE) || (issue && stat.at_last);
    assign in_stall = !can_take;
    assign accept   = in_valid && can_take;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (!stat.div_busy)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (issue && stat.at_last && !accept)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_START;
        endcase
        if (cfg_write)
            state_next = ST_START;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_START;
        else
            state_reg <= state_next;
    end

    assign cmd.div_start = (state_reg == ST_START);
    assign cmd.load      = accept;
    assign cmd.issue     = issue;

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !stat.div_busy)
        else $error("curve taken before step setup finished");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && stat.at_last && !cmd.load && !cfg_write) |=> state_reg == ST_IDLE)
        else $error("run did not end after end anchor");

endmodule

`default_nettype wire
